### rtl/hufd_pkg.sv
package hufd_pkg;

	// Field widths
	localparam int ADDR_W      = 9;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int SIZE_W      = 24;
	localparam int COUNT_W     = SIZE_W + 1;
	localparam int BIT_CNT_W   = $clog2(WORD_W);
	localparam int IN_TDATA_W  = ((ADDR_W + BYTE_W + WORD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 1;

	// Table geometry
	localparam int TABLE_BYTES_DEF = 512;
	localparam int ROOT_POS        = 1;

	// Node byte layout
	localparam logic [7:0] OFF_MASK   = 8'h3F;
	localparam logic [7:0] LEFT_LEAF  = 8'h80;
	localparam logic [7:0] RIGHT_LEAF = 8'h40;

	// Input beat kinds (s_axis_tuser)
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_WORD = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE = 1'b1;

	// Queue entry handed from the front to the back
	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} entry_t;

	// Configuration seen by the back
	typedef struct packed {
		logic [SIZE_W-1:0] size_bytes;
		logic              nibble_mode;
	} cfg_t;

	// One result beat
	typedef struct packed {
		logic [BYTE_W-1:0] symbol;
		logic              last_of_word;
		logic              finished;
	} result_t;

endpackage

### rtl/hufd_front.sv
// Input stage: takes a beat, classifies it and packs it as a queue entry.
module hufd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [8:0] table_addr, [16:9] table_byte, [48:17] stream_word, rest zero
	input  logic [hufd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                             s_axis_tuser,
	output logic                             ent_valid,
	output hufd_pkg::entry_t                 ent,
	input  logic                             ent_ready
);

	localparam int BYTE_LO = hufd_pkg::ADDR_W;
	localparam int WORD_LO = hufd_pkg::ADDR_W + hufd_pkg::BYTE_W;

	logic             valid_s1;
	hufd_pkg::entry_t ent_s1;
	hufd_pkg::entry_t ent_next;
	logic             take;

	assign s_axis_tready = !valid_s1 || ent_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	// Loads keep the byte in the low data bits, words keep the whole word
	always_comb begin
		ent_next.kind = s_axis_tuser;
		ent_next.addr = s_axis_tdata[hufd_pkg::ADDR_W-1:0];
		if (s_axis_tuser == hufd_pkg::CMD_WORD) begin
			ent_next.data = s_axis_tdata[WORD_LO +: hufd_pkg::WORD_W];
		end else begin
			ent_next.data = {{(hufd_pkg::WORD_W - hufd_pkg::BYTE_W){1'b0}},
				s_axis_tdata[BYTE_LO +: hufd_pkg::BYTE_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ent_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= ent_next;
		end
	end

	assign ent_valid = valid_s1;
	assign ent       = ent_s1;

endmodule

### rtl/hufd_queue.sv
// Two-entry queue between the front and the back.
module hufd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  hufd_pkg::entry_t wr_ent,
	output logic             wr_ready,
	output logic             rd_valid,
	output hufd_pkg::entry_t rd_ent,
	input  logic             rd_ready
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	hufd_pkg::entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;
	logic                   push;
	logic                   pop;

	assign wr_ready = count_q != (PTR_W + 1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_ent   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_ent;
		end
	end

endmodule

### rtl/hufd_walk.sv
// Back end: table store, bit-serial tree walk and result register.
module hufd_walk #(
	parameter int TABLE_BYTES = hufd_pkg::TABLE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hufd_pkg::cfg_t        cfg,
	input  logic                  ent_valid,
	input  hufd_pkg::entry_t      ent,
	output logic                  ent_ready,
	output logic                  res_valid,
	output hufd_pkg::result_t     res,
	input  logic                  res_ready
);

	localparam int AW    = $clog2(TABLE_BYTES);
	localparam int WIDE  = hufd_pkg::ADDR_W + 1;
	localparam int MOD_STEPS = 8;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_NODE  = 2'd1;
	localparam logic [1:0] ST_SYM   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam logic [hufd_pkg::BIT_CNT_W-1:0] BIT_LAST = '1;
	localparam logic [AW-1:0] ROOT = AW'(hufd_pkg::ROOT_POS);

	// Reduce an address below the table size; at most seven subtractions for
	// a 9-bit load address, two for a child address
	function automatic logic [WIDE-1:0] mod_tb(input logic [WIDE-1:0] x);
		logic [WIDE-1:0] r;
		r = x;
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (r >= WIDE'(TABLE_BYTES)) begin
				r = r - WIDE'(TABLE_BYTES);
			end
		end
		return r;
	endfunction

	logic [hufd_pkg::BYTE_W-1:0] mem [TABLE_BYTES];
	logic [hufd_pkg::BYTE_W-1:0] rd_q;

	logic [1:0]                      state_q;
	logic [AW-1:0]                   pos_q;
	logic [hufd_pkg::COUNT_W-1:0]    emitted_q;
	logic                            done_q;
	logic [hufd_pkg::WORD_W-1:0]     word_q;
	logic [hufd_pkg::BIT_CNT_W-1:0]  cnt_q;
	logic                            end_q;
	logic                            pend_v_q;
	logic [hufd_pkg::BYTE_W-1:0]     pend_sym_q;
	logic                            pend_fin_q;
	logic                            out_v_q;
	hufd_pkg::result_t               out_q;

	logic [hufd_pkg::COUNT_W-1:0]    target;
	logic [hufd_pkg::COUNT_W-1:0]    emitted_inc;
	logic                            reached;
	logic                            fin_new;
	logic                            bit_b;
	logic                            leaf;
	logic [WIDE-1:0]                 next_raw;
	logic [WIDE-1:0]                 child_red;
	logic [WIDE-1:0]                 load_red;
	logic [AW-1:0]                   child_pos;
	logic [AW-1:0]                   load_addr;
	logic [hufd_pkg::BYTE_W-1:0]     sym_val;
	logic                            out_free;
	logic                            can_emit;
	logic                            ignore_word;

	logic                            mem_we;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic                            push;
	hufd_pkg::result_t               push_res;

	// Expected symbol count and progress
	assign target      = cfg.nibble_mode ? {cfg.size_bytes, 1'b0} : {1'b0, cfg.size_bytes};
	assign reached     = emitted_q >= target;
	assign emitted_inc = emitted_q + 1'b1;
	assign fin_new     = emitted_inc >= target;
	assign ignore_word = done_q || reached;

	// Child address from the node byte in rd_q
	assign bit_b    = word_q[hufd_pkg::WORD_W-1];
	assign leaf     = bit_b ? ((rd_q & hufd_pkg::RIGHT_LEAF) != '0)
	                        : ((rd_q & hufd_pkg::LEFT_LEAF) != '0);
	assign next_raw = WIDE'({pos_q[AW-1:1], 1'b0})
	                + WIDE'({(rd_q & hufd_pkg::OFF_MASK), 1'b0})
	                + WIDE'(2) + WIDE'(bit_b);
	assign child_red = mod_tb(next_raw);
	assign load_red  = mod_tb(WIDE'(ent.addr));
	assign child_pos = child_red[AW-1:0];
	assign load_addr = load_red[AW-1:0];

	assign sym_val  = cfg.nibble_mode ? {4'b0, rd_q[3:0]} : rd_q;
	assign out_free = !out_v_q || res_ready;
	assign can_emit = !pend_v_q || out_free;

	// Table port, queue pop and result push
	always_comb begin
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = pos_q;
		ent_ready = 1'b0;
		push      = 1'b0;
		push_res.symbol       = pend_sym_q;
		push_res.last_of_word = 1'b0;
		push_res.finished     = pend_fin_q;
		case (state_q)
			ST_IDLE: begin
				ent_ready = 1'b1;
				if (ent_valid) begin
					if (ent.kind == hufd_pkg::CMD_LOAD) begin
						mem_we = 1'b1;
					end else if (!ignore_word) begin
						rd_en = 1'b1;
					end
				end
			end
			ST_NODE: begin
				rd_addr = child_pos;
				if (leaf || cnt_q != BIT_LAST) begin
					rd_en = 1'b1;
				end
			end
			ST_SYM: begin
				rd_addr = ROOT;
				if (can_emit) begin
					push = pend_v_q;
					if (!fin_new && !end_q) begin
						rd_en = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push = 1'b1;
					push_res.last_of_word = 1'b1;
				end
			end
			default: begin
				ent_ready = 1'b0;
			end
		endcase
	end

	// Tree table store, single port with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_addr] <= ent.data[hufd_pkg::BYTE_W-1:0];
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= ROOT;
			emitted_q <= '0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			end_q     <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ent_valid && ent.kind == hufd_pkg::CMD_WORD) begin
						if (ignore_word) begin
							done_q <= done_q || (reached && target != '0);
						end else begin
							cnt_q   <= '0;
							state_q <= ST_NODE;
						end
					end
				end
				ST_NODE: begin
					cnt_q <= cnt_q + 1'b1;
					end_q <= cnt_q == BIT_LAST;
					pos_q <= child_pos;
					if (leaf) begin
						state_q <= ST_SYM;
					end else if (cnt_q == BIT_LAST) begin
						state_q <= pend_v_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_SYM: begin
					if (can_emit) begin
						pend_v_q  <= 1'b1;
						emitted_q <= emitted_inc;
						pos_q     <= ROOT;
						if (fin_new) begin
							done_q  <= 1'b1;
							state_q <= ST_FLUSH;
						end else if (end_q) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_NODE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Word shifter and pending symbol payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ent_valid && ent.kind == hufd_pkg::CMD_WORD) begin
			word_q <= ent.data;
		end else if (state_q == ST_NODE) begin
			word_q <= word_q << 1;
		end
		if (state_q == ST_SYM && can_emit) begin
			pend_sym_q <= sym_val;
			pend_fin_q <= fin_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_res;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

### rtl/huffman_tree_walk_decoder_top.sv
// Huffman tree-walk decoder. Send table bytes as beats with tuser = 0, then
// stream words with tuser = 1; each word is walked from bit 31 down, one tree
// node per cycle while the output is not held off, and every leaf gives one
// output beat (tlast marks the last symbol of a word, tuser the symbol that
// completes the expected count). The back end writes a table byte as it is
// taken; a stream word takes a step per bit, one per symbol it yields and a
// flush step for its last symbol if it yields any, set by the single port of
// the table store (one node read per bit, one extra read per leaf symbol); a
// held-off output stalls it. A word that finishes the count ends early.
// A two-entry queue lets the input side keep accepting beats while the
// walker is busy. Write size_bytes and nibble_mode only while idle.
module huffman_tree_walk_decoder_top #(
	parameter int TABLE_BYTES = hufd_pkg::TABLE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hufd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hufd_pkg::SIZE_W-1:0]         cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [8:0] table_addr, [16:9] table_byte, [48:17] stream_word, rest zero
	input  logic [hufd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [0] command
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] symbol
	output logic [hufd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// last_of_word
	output logic                                m_axis_tlast,
	// [0] finished
	output logic                                m_axis_tuser
);

	hufd_pkg::cfg_t    cfg_q;
	logic              f_valid;
	hufd_pkg::entry_t  f_ent;
	logic              f_ready;
	logic              q_valid;
	hufd_pkg::entry_t  q_ent;
	logic              q_ready;
	hufd_pkg::result_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_bytes  <= '0;
			cfg_q.nibble_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hufd_pkg::REG_SIZE:   cfg_q.size_bytes  <= cfg_wdata;
				hufd_pkg::REG_NIBBLE: cfg_q.nibble_mode <= cfg_wdata[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	hufd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ent_valid     (f_valid),
		.ent           (f_ent),
		.ent_ready     (f_ready)
	);

	hufd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ent   (f_ent),
		.wr_ready (f_ready),
		.rd_valid (q_valid),
		.rd_ent   (q_ent),
		.rd_ready (q_ready)
	);

	hufd_walk #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ent_valid (q_valid),
		.ent       (q_ent),
		.ent_ready (q_ready),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = res.symbol;
	assign m_axis_tlast = res.last_of_word;
	assign m_axis_tuser = res.finished;

endmodule

### rtl/hufd_checker.sv
// Port-level checks for the decoder.
module hufd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hufd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hufd_pkg::SIZE_W-1:0]      cfg_wdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [hufd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             m_axis_tlast,
	input  logic                             m_axis_tuser
);

	logic nibble_q;
	logic seen_fin_q;

	// Shadow of the mode register and of a delivered final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_q   <= 1'b0;
			seen_fin_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == hufd_pkg::REG_NIBBLE) begin
				nibble_q <= cfg_wdata[0];
			end
			if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
				seen_fin_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("final symbol not marked as last of word");

	a_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && nibble_q |-> m_axis_tdata[7:4] == 4'b0)
		else $error("upper nibble set in nibble mode");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		seen_fin_q |-> !m_axis_tvalid)
		else $error("output beat after the final symbol");

endmodule

bind huffman_tree_walk_decoder_top hufd_checker u_hufd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_wdata     (cfg_wdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/sv/huffman_tree_walk_decoder_top_tb.sv
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_top_tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 220;
	localparam int MAX_SHOWN     = 10;
	localparam int IDLE_PCT      = 37;
	localparam int STALL_CYCLES  = 400;
	localparam int PHASE_BEATS   = 40;

	// Tree layout: two random-tree regions plus a fixed wrapping tree elsewhere
	localparam int MAX_LEAVES  = 21;
	localparam int REGION_SPAN = 2 * (MAX_LEAVES - 1);
	localparam int BASE_A      = 2;
	localparam int BASE_B      = BASE_A + REGION_SPAN;

	localparam logic [hufd_pkg::ADDR_W-1:0] ROOT_ADDR = hufd_pkg::ADDR_W'(hufd_pkg::ROOT_POS);

	typedef enum int {REGION_ROOT, REGION_A, REGION_B, REGION_WRAP} region_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [hufd_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [hufd_pkg::SIZE_W-1:0]      cfg_wdata;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [hufd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [hufd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             m_axis_tuser;

	// Decoder state mirror
	logic [hufd_pkg::BYTE_W-1:0]  tree_mem [hufd_pkg::TABLE_BYTES_DEF];
	logic [hufd_pkg::ADDR_W-1:0]  walk_pos;
	logic [hufd_pkg::COUNT_W-1:0] sym_count;
	bit                           decode_done;
	logic [hufd_pkg::SIZE_W-1:0]  size_reg;
	bit                           nibble_reg;
	hufd_pkg::result_t            symbol_q [$];

	// Run bookkeeping
	int unsigned cycles;
	int unsigned beats_sent;
	int unsigned loads_sent;
	int unsigned symbols_checked;
	int unsigned reg_writes;
	int unsigned mismatches;
	bit          src_idle;
	bit          sink_idle;
	int unsigned stall_req;
	int unsigned stall_left;

	huffman_tree_walk_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Work out the symbols one accepted input beat produces
	task automatic predict_symbols(input logic cmd, input logic [hufd_pkg::ADDR_W-1:0] addr,
		input logic [hufd_pkg::BYTE_W-1:0] tbyte, input logic [hufd_pkg::WORD_W-1:0] word);
		logic [hufd_pkg::COUNT_W-1:0] goal;
		logic [hufd_pkg::BYTE_W-1:0]  node;
		logic [9:0]                   child;
		logic                         b;
		bit                           is_leaf;
		bit                           stop;
		int                           produced;
		hufd_pkg::result_t            sym_beat;
		produced = 0;
		stop = 1'b0;
		goal = nibble_reg ? {size_reg, 1'b0} : {1'b0, size_reg};
		if (cmd == hufd_pkg::CMD_LOAD) begin
			tree_mem[addr] = tbyte;
		end else if (decode_done || sym_count >= goal) begin
			// word dropped; a lowered nonzero count latches done here
			if (goal != 0 && sym_count >= goal)
				decode_done = 1'b1;
		end else begin
			for (int i = hufd_pkg::WORD_W - 1; i >= 0 && !stop; i--) begin
				b = word[i];
				node = tree_mem[walk_pos];
				is_leaf = b ? ((node & hufd_pkg::RIGHT_LEAF) != 0)
					: ((node & hufd_pkg::LEFT_LEAF) != 0);
				child = {1'b0, walk_pos[hufd_pkg::ADDR_W-1:1], 1'b0}
					+ {1'b0, node & hufd_pkg::OFF_MASK, 1'b0} + 10'd2 + 10'(b);
				walk_pos = child[hufd_pkg::ADDR_W-1:0];
				if (is_leaf) begin
					sym_beat.symbol = nibble_reg ? (tree_mem[walk_pos] & 8'h0F)
						: tree_mem[walk_pos];
					sym_beat.last_of_word = 1'b0;
					sym_count = sym_count + 1'b1;
					walk_pos = ROOT_ADDR;
					sym_beat.finished = (sym_count >= goal);
					if (sym_beat.finished) begin
						decode_done = 1'b1;
						stop = 1'b1;
					end
					symbol_q.insert(symbol_q.size(), sym_beat);
					produced++;
				end
			end
			if (produced > 0)
				symbol_q[symbol_q.size() - 1].last_of_word = 1'b1;
		end
	endtask

	// Offer one beat, random gaps in front, until the block takes it
	task automatic send_beat(input logic cmd, input logic [hufd_pkg::ADDR_W-1:0] addr,
		input logic [hufd_pkg::BYTE_W-1:0] tbyte, input logic [hufd_pkg::WORD_W-1:0] word);
		logic [hufd_pkg::IN_TDATA_W-1:0] beat_data;
		beat_data = '0;
		beat_data[0 +: hufd_pkg::ADDR_W] = addr;
		beat_data[hufd_pkg::ADDR_W +: hufd_pkg::BYTE_W] = tbyte;
		beat_data[hufd_pkg::ADDR_W + hufd_pkg::BYTE_W +: hufd_pkg::WORD_W] = word;
		while (src_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= beat_data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_symbols(cmd, addr, tbyte, word);
		beats_sent++;
		if (cmd == hufd_pkg::CMD_LOAD)
			loads_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [hufd_pkg::ADDR_W-1:0] addr,
		input logic [hufd_pkg::BYTE_W-1:0] tbyte);
		send_beat(hufd_pkg::CMD_LOAD, addr, tbyte, $urandom);
	endtask

	task automatic send_word(input logic [hufd_pkg::WORD_W-1:0] word);
		send_beat(hufd_pkg::CMD_WORD, 9'($urandom), 8'($urandom), word);
	endtask

	// Sender holds off until all symbols are out and the block has settled
	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (symbol_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [hufd_pkg::CFG_IDX_W-1:0] idx,
		input logic [hufd_pkg::SIZE_W-1:0] val);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hufd_pkg::REG_SIZE: size_reg = val;
			hufd_pkg::REG_NIBBLE: nibble_reg = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	function automatic logic [hufd_pkg::BYTE_W-1:0] leaf_symbol();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [hufd_pkg::WORD_W-1:0] stream_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Table bytes that no tree ever reads
	function automatic logic [hufd_pkg::ADDR_W-1:0] spare_addr();
		case ($urandom_range(0, 3))
			0: return 9'd0;
			1: return 9'($urandom_range(130, 255));
			2: return 9'($urandom_range(258, 383));
			default: return 9'($urandom_range(386, 509));
		endcase
	endfunction

	function automatic region_t region_of(input logic [hufd_pkg::ADDR_W-1:0] p);
		if (p == ROOT_ADDR)
			return REGION_ROOT;
		if (p >= BASE_A && p < BASE_B)
			return REGION_A;
		if (p >= BASE_B && p < BASE_B + REGION_SPAN)
			return REGION_B;
		return REGION_WRAP;
	endfunction

	// Complete random tree, child pairs handed out in breadth-first order from base
	task automatic load_random_tree(input int unsigned base, input int unsigned leaves);
		int unsigned open_nodes [$];
		int unsigned pos;
		int unsigned kids;
		int unsigned used;
		logic [hufd_pkg::BYTE_W-1:0] node;
		bit inner_l;
		bit inner_r;
		open_nodes.insert(0, int'(hufd_pkg::ROOT_POS));
		kids = base;
		used = 0;
		while (open_nodes.size() > 0) begin
			pos = open_nodes.pop_front();
			used++;
			node = 8'((kids - (pos & ~32'd1) - 2) / 2);
			inner_l = (used + open_nodes.size() < leaves - 1) && $urandom_range(0, 1);
			if (inner_l)
				open_nodes.insert(open_nodes.size(), kids);
			inner_r = (used + open_nodes.size() < leaves - 1) && $urandom_range(0, 1);
			if (inner_r)
				open_nodes.insert(open_nodes.size(), kids + 1);
			if (!inner_l)
				node = node | hufd_pkg::LEFT_LEAF;
			if (!inner_r)
				node = node | hufd_pkg::RIGHT_LEAF;
			send_load(9'(pos), node);
			if (!inner_l)
				send_load(9'(kids), leaf_symbol());
			if (!inner_r)
				send_load(9'(kids + 1), leaf_symbol());
			kids += 2;
		end
	endtask

	// Chain of right children hopping by the largest offsets; the deepest one wraps
	task automatic load_wrap_tree(input bit random_leaves);
		logic [hufd_pkg::BYTE_W-1:0] leaf_val [6];
		leaf_val = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'hC3};
		if (random_leaves)
			foreach (leaf_val[i])
				leaf_val[i] = leaf_symbol();
		send_load(9'd1, hufd_pkg::LEFT_LEAF | 8'd63);
		send_load(9'd128, leaf_val[0]);
		send_load(9'd129, hufd_pkg::LEFT_LEAF | 8'd63);
		send_load(9'd256, leaf_val[1]);
		send_load(9'd257, hufd_pkg::LEFT_LEAF | 8'd63);
		send_load(9'd384, leaf_val[2]);
		send_load(9'd385, hufd_pkg::LEFT_LEAF | 8'd62);
		send_load(9'd510, leaf_val[3]);
		// 510 + 50*2 + 2 runs past the end and lands on 100
		send_load(9'd511, hufd_pkg::LEFT_LEAF | hufd_pkg::RIGHT_LEAF | 8'd50);
		send_load(9'd100, leaf_val[4]);
		send_load(9'd101, leaf_val[5]);
	endtask

	// New tree in a region the walk is not parked in, so an open code stays intact
	task automatic load_fresh_tree();
		region_t pick;
		pick = region_t'($urandom_range(REGION_A, REGION_WRAP));
		while (pick == region_of(walk_pos))
			pick = region_t'($urandom_range(REGION_A, REGION_WRAP));
		case (pick)
			REGION_A: load_random_tree(BASE_A, $urandom_range(2, MAX_LEAVES));
			REGION_B: load_random_tree(BASE_B, $urandom_range(2, MAX_LEAVES));
			default: load_wrap_tree(1'b1);
		endcase
	endtask

	// Words with a zero count are dropped without touching the table
	task automatic test_zero_count();
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_load(9'd0, 8'h00);
	endtask

	// Full words of short codes, a code left open across words, address wrap
	task automatic test_wrap_walk();
		load_wrap_tree(1'b0);
		write_reg(hufd_pkg::REG_SIZE, 24'hFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'hE000_0000);
		send_word(32'h1234_5678);
	endtask

	task automatic test_nibble_symbols();
		write_reg(hufd_pkg::REG_NIBBLE, 24'd1);
		send_word(32'hFFFF_FFFF);
		send_word(32'h5A5A_5A5A);
		write_reg(hufd_pkg::REG_NIBBLE, 24'd0);
	endtask

	// Count set to zero mid-decode pauses the walk without finishing it
	task automatic test_paused_count();
		write_reg(hufd_pkg::REG_SIZE, '0);
		send_word($urandom);
		send_word($urandom);
		write_reg(hufd_pkg::REG_SIZE, 24'hFF_FFFF);
	endtask

	task automatic test_tree_reload();
		repeat (3) begin
			load_fresh_tree();
			repeat (3) send_word(stream_word());
		end
	endtask

	// Output held off long enough for the input side to back up
	task automatic test_input_backpressure();
		stall_req = STALL_CYCLES;
		repeat (10) send_word($urandom);
		wait_all_results();
	endtask

	task automatic test_random_stream();
		int unsigned phase_end;
		int unsigned r;
		for (int phase = 0; phase < 5; phase++) begin
			// middle phase runs both sides flat out
			src_idle = (phase != 2);
			sink_idle = (phase != 2);
			write_reg(hufd_pkg::REG_NIBBLE, 24'($urandom_range(0, 1)));
			if (phase == 0)
				write_reg(hufd_pkg::REG_SIZE, 24'hFF_FFFF);
			else
				write_reg(hufd_pkg::REG_SIZE,
					24'($urandom_range(sym_count + 20000, 24'hFF_FFFF)));
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					load_fresh_tree();
				else if (r < 11)
					send_load(spare_addr(), 8'($urandom));
				else
					send_word(stream_word());
			end
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Count lowered to just past what is out: finishes mid-word, later words dropped
	task automatic test_finish_count();
		write_reg(hufd_pkg::REG_NIBBLE, 24'd1);
		write_reg(hufd_pkg::REG_SIZE, 24'((sym_count >> 1) + 2));
		repeat (6) send_word($urandom);
	endtask

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Receiver: random tready, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !sink_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Symbol checker and run watchdog
	always @(posedge clk) begin : symbol_check
		hufd_pkg::result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d symbols outstanding", cycles,
				symbol_q.size());
			$display("huffman_tree_walk_decoder_top test failed");
			$finish;
		end else if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (symbol_q.size() == 0) begin
				note_failure($sformatf("unexpected beat: sym %02h last %0b fin %0b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser));
			end else begin
				want = symbol_q.pop_front();
				symbols_checked++;
				if (m_axis_tdata !== want.symbol || m_axis_tlast !== want.last_of_word
					|| m_axis_tuser !== want.finished)
					note_failure($sformatf(
						"beat %0d: got sym %02h last %0b fin %0b, want sym %02h last %0b fin %0b",
						symbols_checked, m_axis_tdata, m_axis_tlast, m_axis_tuser,
						want.symbol, want.last_of_word, want.finished));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = hufd_pkg::CMD_LOAD;
		m_axis_tready = 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		stall_req = 0;
		stall_left = 0;
		cycles = 0;
		beats_sent = 0;
		loads_sent = 0;
		symbols_checked = 0;
		reg_writes = 0;
		mismatches = 0;
		foreach (tree_mem[i])
			tree_mem[i] = '0;
		walk_pos = ROOT_ADDR;
		sym_count = '0;
		decode_done = 1'b0;
		size_reg = '0;
		nibble_reg = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_count();
		test_wrap_walk();
		test_nibble_symbols();
		test_paused_count();
		test_tree_reload();
		test_input_backpressure();
		test_random_stream();
		test_finish_count();
		wait_all_results();

		$display("Sent %0d beats (%0d table loads), checked %0d symbols, %0d register writes",
			beats_sent, loads_sent, symbols_checked, reg_writes);
		$display("Byte and nibble symbols, wrapped child addresses, paused and %s decode",
			decode_done ? "completed" : "open");
		if (mismatches == 0 && symbol_q.size() == 0) begin
			$display("huffman_tree_walk_decoder_top test passed");
		end else begin
			$display("%0d failures, %0d symbols never seen", mismatches, symbol_q.size());
			$display("huffman_tree_walk_decoder_top test failed");
		end
		$finish;
	end

endmodule
